### rtl/gvne_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the grid vertex normal estimator.
// Used by gvne_ctrl, gvne_datapath and grid_vertex_normal_estimator_core.
package gvne_pkg;

  localparam int MAX_DIM_DEF = 128;
  localparam logic [7:0] GRID_DIM_RST = 8'd65;

  // Controller states
  typedef enum logic [4:0] {
    ST_IDLE, ST_PICK, ST_RD, ST_CAP, ST_MAG, ST_SCALE, ST_MUL, ST_ACC,
    ST_NZ, ST_NORM, ST_SQ, ST_SQACC, ST_RTINIT, ST_RT, ST_DVINIT, ST_DV,
    ST_DVEND, ST_PUSH
  } state_t;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_READ, OP_CAPT, OP_MAG, OP_SCALE, OP_MUL, OP_ACC,
    OP_NZ, OP_NORM, OP_SQ, OP_SQACC, OP_RTINIT, OP_RTSTEP, OP_DVINIT,
    OP_DVSTEP, OP_DVEND, OP_PUSH
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] idx;    // capture slot: 0 center, 1..4 neighbor
    logic [3:0] have;   // neighbor present: left, up, right, down
    logic [1:0] k;      // cross product term
    logic [1:0] comp;   // component x, y, z
    logic       half;   // second product of a cross term
    logic [6:0] ocol;
    logic [6:0] orow;
    logic       odone;
  } dp_cmd_t;

  typedef struct packed {
    logic zero;
    logic norm_done;
    logic root_done;
    logic out_busy;
  } dp_stat_t;

  function automatic logic [1:0] inc3(logic [1:0] v);
    return (v == 2'd2) ? 2'd0 : 2'(v + 2'd1);
  endfunction

endpackage

### rtl/gvne_ctrl.sv
`timescale 1ns / 1ps
// Controller of the normal estimator: grid position, emission list and the
// step sequencer that drives gvne_datapath. Depends on gvne_pkg.
module gvne_ctrl import gvne_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF,
  parameter int AW = $clog2(3 * MAX_DIM)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [7:0]    cfg_data,
  output dp_cmd_t       cmd,
  output logic [AW-1:0] addr,
  input  dp_stat_t      stat
);

  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int GW = (DW > 8) ? DW : 8;

  state_t state, state_next;
  logic [7:0] grid_dim;
  logic [DW-1:0] col_cnt, row_cnt, acc_col, acc_row, ecol, erow;
  logic [1:0] rslot, acc_slot, eslot;
  logic [2:0] pend;
  logic [4:0] idx;
  logic [1:0] mk, mc;
  logic mh;

  logic [GW-1:0] gd_w, dim_w;
  logic [DW-1:0] dim_eff, dim_m1, wr_col, wr_row, col_p1, row_p1;
  logic [1:0] wr_slot, rd_slot;
  logic [DW-1:0] rd_col;
  logic wrap, accept;
  logic [3:0] have;

  // Effective size: clamp to [2, MAX_DIM]
  always_comb begin
    gd_w = GW'(grid_dim);
    if (gd_w < GW'(2)) begin
      dim_w = GW'(2);
    end else if (gd_w > GW'(MAX_DIM)) begin
      dim_w = GW'(MAX_DIM);
    end else begin
      dim_w = gd_w;
    end
    dim_eff = DW'(dim_w);
    dim_m1  = DW'(dim_eff - DW'(1));
  end

  // Position of the incoming vertex
  assign wrap    = (col_cnt >= dim_eff) || (row_cnt >= dim_eff);
  assign wr_col  = wrap ? '0 : col_cnt;
  assign wr_row  = wrap ? '0 : row_cnt;
  assign wr_slot = wrap ? 2'd0 : rslot;
  assign col_p1  = DW'(wr_col + DW'(1));
  assign row_p1  = DW'(wr_row + DW'(1));

  // Take a grid size write only while idle; it wins over a vertex
  assign s_tready  = (state == ST_IDLE) && !cfg_valid;
  assign cfg_ready = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;

  assign have[0] = (ecol != '0);
  assign have[1] = (erow != '0);
  assign have[2] = (ecol != dim_m1);
  assign have[3] = (erow != dim_m1);

  // Store address for the write or the current neighbor read
  always_comb begin
    rd_slot = eslot;
    rd_col  = ecol;
    case (idx[2:0])
      3'd1: rd_col = have[0] ? DW'(ecol - DW'(1)) : ecol;
      3'd2: rd_slot = inc3(inc3(eslot));
      3'd3: rd_col = have[2] ? DW'(ecol + DW'(1)) : ecol;
      3'd4: rd_slot = inc3(eslot);
      default: ;
    endcase
    if (state == ST_IDLE) begin
      addr = AW'(AW'(wr_slot) * AW'(MAX_DIM) + AW'(wr_col));
    end else begin
      addr = AW'(AW'(rd_slot) * AW'(MAX_DIM) + AW'(rd_col));
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath command
  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.op    = OP_NONE;
    cmd.idx   = idx[2:0];
    cmd.have  = have;
    cmd.k     = mk;
    cmd.comp  = mc;
    cmd.half  = mh;
    cmd.ocol  = 7'(ecol);
    cmd.orow  = 7'(erow);
    cmd.odone = (ecol == dim_m1) && (erow == dim_m1);
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.op = OP_LOAD;
          state_next = ST_PICK;
        end
      end
      ST_PICK: state_next = (pend == 3'b000) ? ST_IDLE : ST_RD;
      ST_RD: begin
        cmd.op = OP_READ;
        state_next = ST_CAP;
      end
      ST_CAP: begin
        cmd.op = OP_CAPT;
        state_next = (idx == 5'd4) ? ST_MAG : ST_RD;
      end
      ST_MAG: begin
        cmd.op = OP_MAG;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.op = OP_SCALE;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.op = OP_MUL;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.op = OP_ACC;
        if (mh && mc == 2'd2 && mk == 2'd3) begin
          state_next = ST_NZ;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_NZ: begin
        cmd.op = OP_NZ;
        state_next = ST_NORM;
      end
      ST_NORM: begin
        if (stat.zero) begin
          state_next = ST_PUSH;
        end else if (stat.norm_done) begin
          state_next = ST_SQ;
        end else begin
          cmd.op = OP_NORM;
        end
      end
      ST_SQ: begin
        cmd.op = OP_SQ;
        state_next = ST_SQACC;
      end
      ST_SQACC: begin
        cmd.op = OP_SQACC;
        state_next = (mc == 2'd2) ? ST_RTINIT : ST_SQ;
      end
      ST_RTINIT: begin
        cmd.op = OP_RTINIT;
        state_next = ST_RT;
      end
      ST_RT: begin
        if (stat.root_done) begin
          state_next = ST_DVINIT;
        end else begin
          cmd.op = OP_RTSTEP;
        end
      end
      ST_DVINIT: begin
        cmd.op = OP_DVINIT;
        state_next = ST_DV;
      end
      ST_DV: begin
        cmd.op = OP_DVSTEP;
        if (idx == 5'd16) begin
          state_next = ST_DVEND;
        end
      end
      ST_DVEND: begin
        cmd.op = OP_DVEND;
        state_next = (mc == 2'd2) ? ST_PUSH : ST_DVINIT;
      end
      ST_PUSH: begin
        if (!stat.out_busy) begin
          cmd.op = OP_PUSH;
          state_next = ST_PICK;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Grid position and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_dim <= GRID_DIM_RST;
      col_cnt  <= '0;
      row_cnt  <= '0;
      rslot    <= 2'd0;
      pend     <= 3'b000;
    end else begin
      if (accept) begin
        acc_col  <= wr_col;
        acc_row  <= wr_row;
        acc_slot <= wr_slot;
        pend <= {(wr_row == dim_m1) && (wr_col == dim_m1),
                 (wr_row == dim_m1) && (wr_col != '0),
                 (wr_row != '0)};
        if (col_p1 >= dim_eff) begin
          col_cnt <= '0;
          if (row_p1 >= dim_eff) begin
            row_cnt <= '0;
            rslot   <= 2'd0;
          end else begin
            row_cnt <= row_p1;
            rslot   <= inc3(wr_slot);
          end
        end else begin
          col_cnt <= col_p1;
          row_cnt <= wr_row;
          rslot   <= wr_slot;
        end
      end
      // Pick the next normal to produce, oldest row first
      if (state == ST_PICK) begin
        if (pend[0]) begin
          pend[0] <= 1'b0;
          ecol  <= acc_col;
          erow  <= DW'(acc_row - DW'(1));
          eslot <= inc3(inc3(acc_slot));
        end else if (pend[1]) begin
          pend[1] <= 1'b0;
          ecol  <= DW'(acc_col - DW'(1));
          erow  <= acc_row;
          eslot <= acc_slot;
        end else if (pend[2]) begin
          pend[2] <= 1'b0;
          ecol  <= acc_col;
          erow  <= acc_row;
          eslot <= acc_slot;
        end
      end
      if (cfg_valid && cfg_ready) begin
        grid_dim <= cfg_data;
        col_cnt  <= '0;
        row_cnt  <= '0;
        rslot    <= 2'd0;
      end
    end
  end

  // Step counters
  always_ff @(posedge clk) begin
    case (state)
      ST_PICK: idx <= 5'd0;
      ST_CAP: idx <= 5'(idx + 5'd1);
      ST_SCALE: begin
        mk <= 2'd0;
        mc <= 2'd0;
        mh <= 1'b0;
      end
      ST_ACC: begin
        mh <= ~mh;
        if (mh) begin
          if (mc == 2'd2) begin
            mc <= 2'd0;
            mk <= 2'(mk + 2'd1);
          end else begin
            mc <= 2'(mc + 2'd1);
          end
        end
      end
      ST_SQACC: mc <= (mc == 2'd2) ? 2'd0 : 2'(mc + 2'd1);
      ST_DVINIT: idx <= 5'd0;
      ST_DV: idx <= 5'(idx + 5'd1);
      ST_DVEND: mc <= 2'(mc + 2'd1);
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_pos_in_grid: assert property (@(posedge clk) disable iff (rst)
    (col_cnt < dim_eff) && (row_cnt < dim_eff))
    else $error("grid position beyond size");
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (pend == 3'b000))
    else $error("idle with normals pending");
  a_slot_valid: assert property (@(posedge clk) disable iff (rst)
    (rslot != 2'd3) && ((state == ST_IDLE) || (eslot != 2'd3) || (state == ST_PICK)))
    else $error("row slot out of range");
`endif

endmodule

### rtl/gvne_datapath.sv
`timescale 1ns / 1ps
// Datapath of the normal estimator: three-row line store, deltas, shared
// multiplier, normalizing shifter, bit-serial square root and divider.
// Depends on gvne_pkg.
module gvne_datapath import gvne_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF,
  parameter int AW = $clog2(3 * MAX_DIM)
) (
  input  logic          clk,
  input  logic          rst,
  input  dp_cmd_t       cmd,
  input  logic [AW-1:0] addr,
  input  logic [95:0]   vdata,
  output dp_stat_t      stat,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [63:0]   m_tdata,
  output logic          m_tlast
);

  logic [95:0] mem [3 * MAX_DIM];
  logic [95:0] rdata, pv;
  logic signed [32:0] dx [4];
  logic signed [32:0] dy [4];
  logic signed [32:0] dz [4];
  logic [1:0] shamt;
  logic [32:0] magor;
  logic signed [31:0] op1, op2;
  logic signed [63:0] mprod, prod;
  logic [1:0] acc_comp;
  logic acc_half;
  logic signed [63:0] sx, sy, sz, csel;
  logic [63:0] mo, sumsq, rv, res, rbit;
  logic [30:0] cmag;
  logic [46:0] num;
  logic [31:0] rem;
  logic [16:0] nb, q;
  logic [32:0] dvt;
  logic neg;
  logic signed [15:0] nrm [3];
  logic signed [15:0] qsat;
  logic [1:0] cj, kb;

  function automatic logic [32:0] mag33(logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic [63:0] mag64(logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // Line store: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      mem[addr] <= vdata;
    end
    if (cmd.op == OP_READ) begin
      rdata <= mem[addr];
    end
  end

  // Shared values: OR of delta magnitudes, multiplier operands
  assign cj = 2'(cmd.idx - 3'd1);
  assign kb = 2'(cmd.k + 2'd1);

  always_comb begin
    magor = '0;
    for (int i = 0; i < 4; i++) begin
      magor = magor | mag33(dx[i]) | mag33(dy[i]) | mag33(dz[i]);
    end
    case (cmd.comp)
      2'd0: csel = sx;
      2'd1: csel = sy;
      default: csel = sz;
    endcase
    op1 = csel[31:0];
    op2 = csel[31:0];
    if (cmd.op == OP_MUL) begin
      case (cmd.comp)
        2'd0: begin
          op1 = cmd.half ? dz[cmd.k][31:0] : dy[cmd.k][31:0];
          op2 = cmd.half ? dy[kb][31:0] : dz[kb][31:0];
        end
        2'd1: begin
          op1 = cmd.half ? dx[cmd.k][31:0] : dz[cmd.k][31:0];
          op2 = cmd.half ? dz[kb][31:0] : dx[kb][31:0];
        end
        default: begin
          op1 = cmd.half ? dy[cmd.k][31:0] : dx[cmd.k][31:0];
          op2 = cmd.half ? dx[kb][31:0] : dy[kb][31:0];
        end
      endcase
    end
    mprod = op1 * op2;
    cmag = csel[31] ? 31'(-csel[31:0]) : 31'(csel[31:0]);
    num  = (47'(cmag) << 15) + 47'(res[31:1]);
    dvt  = {rem, nb[16]};
    if (neg) begin
      qsat = (q >= 17'd32768) ? 16'sh8000 : 16'(~q + 17'd1);
    end else begin
      qsat = (q >= 17'd32767) ? 16'sh7fff : 16'(q);
    end
  end

  // Status for the controller
  assign stat.zero      = (mo == '0);
  assign stat.norm_done = (mo[63:30] == '0) && mo[29];
  assign stat.root_done = (rbit == '0);
  assign stat.out_busy  = m_tvalid && !m_tready;

  // Arithmetic steps
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPT: begin
        if (cmd.idx == 3'd0) begin
          pv <= rdata;
        end else if (cmd.have[cj]) begin
          dx[cj] <= 33'(signed'(rdata[31:0])) - 33'(signed'(pv[31:0]));
          dy[cj] <= 33'(signed'(rdata[63:32])) - 33'(signed'(pv[63:32]));
          dz[cj] <= 33'(signed'(rdata[95:64])) - 33'(signed'(pv[95:64]));
        end else begin
          dx[cj] <= '0;
          dy[cj] <= '0;
          dz[cj] <= '0;
        end
      end
      OP_MAG: begin
        if (magor[32]) begin
          shamt <= 2'd3;
        end else if (magor[31]) begin
          shamt <= 2'd2;
        end else if (magor[30]) begin
          shamt <= 2'd1;
        end else begin
          shamt <= 2'd0;
        end
      end
      OP_SCALE: begin
        for (int i = 0; i < 4; i++) begin
          dx[i] <= dx[i] >>> shamt;
          dy[i] <= dy[i] >>> shamt;
          dz[i] <= dz[i] >>> shamt;
        end
        sx <= '0;
        sy <= '0;
        sz <= '0;
      end
      OP_MUL, OP_SQ: begin
        prod     <= mprod;
        acc_comp <= cmd.comp;
        acc_half <= cmd.half;
      end
      OP_ACC: begin
        case (acc_comp)
          2'd0: sx <= acc_half ? sx - prod : sx + prod;
          2'd1: sy <= acc_half ? sy - prod : sy + prod;
          default: sz <= acc_half ? sz - prod : sz + prod;
        endcase
      end
      OP_NZ: begin
        mo    <= mag64(sx) | mag64(sy) | mag64(sz);
        sumsq <= '0;
      end
      OP_NORM: begin
        if (mo[63:30] != '0) begin
          sx <= sx >>> 1;
          sy <= sy >>> 1;
          sz <= sz >>> 1;
          mo <= mo >> 1;
        end else begin
          sx <= sx <<< 1;
          sy <= sy <<< 1;
          sz <= sz <<< 1;
          mo <= mo << 1;
        end
      end
      OP_SQACC: sumsq <= sumsq + prod;
      OP_RTINIT: begin
        rv   <= sumsq;
        res  <= '0;
        rbit <= 64'h4000_0000_0000_0000;
      end
      OP_RTSTEP: begin
        if (rv >= res + rbit) begin
          rv  <= rv - (res + rbit);
          res <= (res >> 1) + rbit;
        end else begin
          res <= res >> 1;
        end
        rbit <= rbit >> 2;
      end
      OP_DVINIT: begin
        rem <= 32'(num[46:17]);
        nb  <= num[16:0];
        q   <= '0;
        neg <= csel[31];
      end
      OP_DVSTEP: begin
        if (dvt >= {1'b0, res[31:0]}) begin
          rem <= 32'(dvt - {1'b0, res[31:0]});
          q   <= {q[15:0], 1'b1};
        end else begin
          rem <= dvt[31:0];
          q   <= {q[15:0], 1'b0};
        end
        nb <= {nb[15:0], 1'b0};
      end
      OP_DVEND: nrm[cmd.comp] <= qsat;
      default: ;
    endcase
  end

  // Output register: hold a finished item until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.op == OP_PUSH) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (cmd.op == OP_PUSH) begin
      if (stat.zero) begin
        m_tdata <= {2'b00, cmd.orow, cmd.ocol, 48'd0};
      end else begin
        m_tdata <= {2'b00, cmd.orow, cmd.ocol, nrm[2], nrm[1], nrm[0]};
      end
      m_tlast <= cmd.odone;
    end
  end

`ifndef ASSERT_OFF
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_DVINIT) |-> ((res[63:32] == '0) && (res[31:29] != '0)))
    else $error("root out of expected range");
  a_rem_below_len: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_DVINIT) |=> (rem < res[31:0]))
    else $error("division start remainder too large");
  a_quot_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_DVEND) |-> (q <= 17'd32768))
    else $error("normal component quotient above one");
`endif

endmodule

### rtl/grid_vertex_normal_estimator_core.sv
`timescale 1ns / 1ps
// Top level of the grid vertex normal estimator: controller plus datapath.
// Depends on gvne_pkg, gvne_ctrl and gvne_datapath.
//
//   channel  | dir | handshake          | payload
//   s_*      | in  | s_tvalid/s_tready  | s_tdata: vertex_x, vertex_y, vertex_z
//   m_*      | out | m_tvalid/m_tready  | m_tdata: normals, grid_column, grid_row
//                                       | m_tlast: grid_done
//   cfg_*    | in  | cfg_valid/cfg_ready| cfg_data: grid_dim
//
// A vertex is taken and gives zero to three normals; the controller then returns to idle.
// A normal runs five store reads, 24 products, a normalizing shift, a 32-step root and
// three divides; when its sum is zero it skips the shift, the root and the divides.
// No vertex or grid size write is taken until the normals are done; a finished normal
// waits in the output register and holds off the next push while m_tready is low.
// Reset is synchronous; the line store needs no clearing pass.
module grid_vertex_normal_estimator_core import gvne_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // vertex_x [31:0], vertex_y [63:32], vertex_z [95:64]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // normal_x, normal_y, normal_z (16 each), grid_column 7,
                                 // grid_row 7, zero fill
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam int AW = $clog2(3 * MAX_DIM);

  dp_cmd_t cmd;
  dp_stat_t stat;
  logic [AW-1:0] addr;

  gvne_ctrl #(.MAX_DIM(MAX_DIM), .AW(AW)) u_ctrl (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .cmd(cmd), .addr(addr), .stat(stat)
  );

  gvne_datapath #(.MAX_DIM(MAX_DIM), .AW(AW)) u_dp (
    .clk(clk), .rst(rst),
    .cmd(cmd), .addr(addr), .vdata(s_tdata), .stat(stat),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

endmodule

### test/normal_checker.sv
`timescale 1ns / 1ps
// Watches the vertex, normal and grid size channels of the normal estimator,
// predicts every normal from the accepted vertices and compares in order.
// Depends on nothing but the core's port widths.
module normal_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [95:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  input  logic        m_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  output int          error_count,
  output int          pending
);

  localparam int MAX_DIM = 128;

  typedef struct {
    logic signed [15:0] nx, ny, nz;
    logic [6:0]         col, row;
    logic               done;
  } normal_t;

  normal_t expected_normals[$];

  // Line store of three rows and the grid position of the next vertex
  longint      row_x [3*MAX_DIM];
  longint      row_y [3*MAX_DIM];
  longint      row_z [3*MAX_DIM];
  int unsigned col_cnt, row_cnt;
  logic [7:0]  grid_dim;

  function automatic longint unsigned magn(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] unit_comp(longint s, longint unsigned len);
    longint unsigned q;
    q = (magn(s) * 64'd32768 + len / 2) / len;
    if (s < 0) return (q >= 32768) ? 16'sh8000 : 16'(-longint'(q));
    return (q >= 32767) ? 16'sd32767 : 16'(q);
  endfunction

  // Normal of vertex (c, r): sum of neighbor delta cross products, normalized
  function automatic normal_t vertex_normal(int c, int r, int d);
    normal_t n;
    longint px, py, pz, sx, sy, sz;
    longint dx [4], dy [4], dz [4];
    int nc [4], nr [4];
    bit have [4];
    longint unsigned m, len;
    int s, k, j, idx;
    idx = (r % 3) * MAX_DIM + c;
    px = row_x[idx]; py = row_y[idx]; pz = row_z[idx];
    nc = '{c - 1, c, c + 1, c};
    nr = '{r, r - 1, r, r + 1};
    have = '{c >= 1, r >= 1, c + 1 < d, r + 1 < d};
    m = 0;
    for (k = 0; k < 4; k++) begin
      dx[k] = 0; dy[k] = 0; dz[k] = 0;
      if (have[k]) begin
        idx = (nr[k] % 3) * MAX_DIM + nc[k];
        dx[k] = row_x[idx] - px;
        dy[k] = row_y[idx] - py;
        dz[k] = row_z[idx] - pz;
        if (magn(dx[k]) > m) m = magn(dx[k]);
        if (magn(dy[k]) > m) m = magn(dy[k]);
        if (magn(dz[k]) > m) m = magn(dz[k]);
      end
    end
    s = 0;
    while ((m >> s) >= (64'd1 << 30)) s++;
    for (k = 0; k < 4; k++) begin
      dx[k] = dx[k] >>> s; dy[k] = dy[k] >>> s; dz[k] = dz[k] >>> s;
    end
    sx = 0; sy = 0; sz = 0;
    for (k = 0; k < 4; k++) begin
      j = (k + 1) % 4;
      sx += dy[k] * dz[j] - dz[k] * dy[j];
      sy += dz[k] * dx[j] - dx[k] * dz[j];
      sz += dx[k] * dy[j] - dy[k] * dx[j];
    end
    m = magn(sx);
    if (magn(sy) > m) m = magn(sy);
    if (magn(sz) > m) m = magn(sz);
    if (m == 0) begin
      n.nx = 0; n.ny = 0; n.nz = 0;
    end else begin
      s = 0;
      while ((m >> s) >= (64'd1 << 30)) s++;
      sx = sx >>> s; sy = sy >>> s; sz = sz >>> s;
      m = m >> s;
      while (m < (64'd1 << 29)) begin
        m = m * 2; sx = sx * 2; sy = sy * 2; sz = sz * 2;
      end
      len = isqrt(longint'(sx * sx) + longint'(sy * sy) + longint'(sz * sz));
      n.nx = unit_comp(sx, len);
      n.ny = unit_comp(sy, len);
      n.nz = unit_comp(sz, len);
    end
    n.col = 7'(c);
    n.row = 7'(r);
    n.done = (c == d - 1) && (r == d - 1);
    return n;
  endfunction

  // Append one expected normal
  task automatic queue_normal(normal_t n);
    expected_normals = {expected_normals, n};
  endtask

  // Store one vertex and queue the normals it completes
  task automatic take_vertex(logic [95:0] data);
    int d, c, r;
    d = (grid_dim < 2) ? 2 : (grid_dim > MAX_DIM) ? MAX_DIM : int'(grid_dim);
    c = col_cnt; r = row_cnt;
    if (c >= d || r >= d) begin
      c = 0; r = 0;
    end
    row_x[(r % 3) * MAX_DIM + c] = longint'($signed(data[31:0]));
    row_y[(r % 3) * MAX_DIM + c] = longint'($signed(data[63:32]));
    row_z[(r % 3) * MAX_DIM + c] = longint'($signed(data[95:64]));
    if (r >= 1) queue_normal(vertex_normal(c, r - 1, d));
    if (r == d - 1) begin
      if (c >= 1) queue_normal(vertex_normal(c - 1, r, d));
      if (c == d - 1) queue_normal(vertex_normal(c, r, d));
    end
    c++;
    if (c >= d) begin
      c = 0;
      r++;
      if (r >= d) r = 0;
    end
    col_cnt = c; row_cnt = r;
  endtask

  // Compare one delivered normal with the oldest expectation
  task automatic check_normal();
    normal_t e;
    if (expected_normals.size() == 0) begin
      $error("unexpected normal: tdata %h tlast %b", m_tdata, m_tlast);
      error_count++;
      return;
    end
    e = expected_normals.pop_front();
    if (m_tdata[15:0] !== e.nx) begin
      $error("normal_x: expected %0d, actual %0d", e.nx, $signed(m_tdata[15:0]));
      error_count++;
    end
    if (m_tdata[31:16] !== e.ny) begin
      $error("normal_y: expected %0d, actual %0d", e.ny, $signed(m_tdata[31:16]));
      error_count++;
    end
    if (m_tdata[47:32] !== e.nz) begin
      $error("normal_z: expected %0d, actual %0d", e.nz, $signed(m_tdata[47:32]));
      error_count++;
    end
    if (m_tdata[54:48] !== e.col) begin
      $error("grid_column: expected %0d, actual %0d", e.col, m_tdata[54:48]);
      error_count++;
    end
    if (m_tdata[61:55] !== e.row) begin
      $error("grid_row: expected %0d, actual %0d", e.row, m_tdata[61:55]);
      error_count++;
    end
    if (m_tlast !== e.done) begin
      $error("grid_done: expected %0d, actual %0d", e.done, m_tlast);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_normals.delete();
      error_count = 0;
      col_cnt = 0;
      row_cnt = 0;
      grid_dim = 8'd65;
    end else begin
      if (cfg_valid && cfg_ready) begin
        grid_dim = cfg_data;
        col_cnt = 0;
        row_cnt = 0;
      end
      if (m_tvalid && m_tready) check_normal();
      if (s_tvalid && s_tready) take_vertex(s_tdata);
    end
    pending <= expected_normals.size();
  end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// Top of the normal estimator regression: clock, reset, vertex and grid size
// stimulus, output back-pressure and verdict. Depends on the core and normal_checker.
module testbench;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;
  logic        hold_request = 1'b0;
  int          error_count, pending;
  int          vertex_count = 0;
  longint      cycle_count = 0;

  localparam int SETTLE_CYCLES = 800;
  localparam int HOLD_CYCLES = 3000;

  always #10 clk = ~clk;

  grid_vertex_normal_estimator_core i_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
    .m_tdata, .m_tlast, .cfg_valid, .cfg_ready, .cfg_data
  );

  normal_checker i_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
    .m_tdata, .m_tlast, .cfg_valid, .cfg_ready, .cfg_data, .error_count, .pending
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 6000000) begin
      $display("grid_vertex_normal_estimator_core regression: fail");
      $finish;
    end
  end

  // One random stretch of output ready: mostly short, a few long hold-offs
  task automatic ready_step();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end else begin
      m_tready <= 1'b0;
      repeat (pick < 9 ? $urandom_range(1, 4) : $urandom_range(20, 300)) @(posedge clk);
    end
  endtask

  // Drive output ready: random gaps, one long hold-off while vertices keep coming
  initial begin
    @(negedge rst);
    while (!hold_request) ready_step();
    m_tready <= 1'b0;
    repeat (HOLD_CYCLES) @(posedge clk);
    forever ready_step();
  end

  function automatic int sender_gap();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 14) return 0;
    if (pick < 19) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // Offer one vertex and hold it until accepted
  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {z, y, x};
    do @(posedge clk); while (!s_tready);
    vertex_count++;
  endtask

  // Drain all normals, let the block settle, then write the grid size
  task automatic write_grid_dim(logic [7:0] value);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Vertex content: full random, terrain-like, or flat
  task automatic send_grid_vertex(int shape, int c, int r);
    case (shape)
      0: send_vertex($urandom, $urandom, $urandom);
      1: send_vertex(32'(c * 256 + $urandom_range(0, 63)),
                     32'(r * 256 + $urandom_range(0, 63)),
                     32'($signed($urandom_range(0, 8191)) - 4096));
      2: send_vertex(32'(c * 1024), 32'(r * 1024), 32'h0000_0100);
      default: send_vertex(32'h1234_5678, 32'hedcb_a987, 32'h0f0f_0f0f);
    endcase
  endtask

  initial begin
    int d, n, limit, shape, i;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Extremes of every field on the smallest grid (size below minimum)
    write_grid_dim(8'd0);
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000);
    send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vertex(32'h0000_0000, 32'h0000_0000, 32'h8000_0000);
    send_vertex(32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff);
    // Flat grid gives zero sums
    for (i = 0; i < 4; i++) send_grid_vertex(3, 0, 0);
    // Size one acts as two; then a write mid-grid restarts it
    write_grid_dim(8'd1);
    send_grid_vertex(1, 0, 0);
    send_grid_vertex(1, 1, 0);
    write_grid_dim(8'd3);
    for (i = 0; i < 9; i++) send_grid_vertex(1, i % 3, i / 3);

    // Largest size, written over range and at range, fed part of the grid;
    // the output is held off while the first rows stream in
    write_grid_dim(8'd255);
    hold_request <= 1'b1;
    for (i = 0; i < 131; i++) send_grid_vertex(i % 2, i % 128, i / 128);
    write_grid_dim(8'd128);
    for (i = 0; i < 130; i++) send_grid_vertex(1, i % 128, i / 128);

    // Random small grids, mostly whole, some cut short, some back to back
    while (vertex_count < 440) begin
      d = $urandom_range(2, 6);
      write_grid_dim(8'(d));
      shape = $urandom_range(0, 9) < 5 ? 0 : $urandom_range(1, 3);
      n = ($urandom_range(0, 3) == 0) ? 2 * d * d : d * d;
      limit = ($urandom_range(0, 7) == 0) ? $urandom_range(1, n - 1) : n;
      for (i = 0; i < limit; i++) send_grid_vertex(shape, i % d, (i / d) % d);
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending == 0) begin
      $display("grid_vertex_normal_estimator_core regression: pass");
    end else begin
      $display("grid_vertex_normal_estimator_core regression: fail");
    end
    $finish;
  end

endmodule

### grid_vertex_normal_estimator_core.f
rtl/gvne_pkg.sv
rtl/gvne_ctrl.sv
rtl/gvne_datapath.sv
rtl/grid_vertex_normal_estimator_core.sv
test/normal_checker.sv
test/testbench.sv
